[hdl/lvif_pkg.sv]
// shared types, tap table and constants for the luma vertical interpolation filter
`timescale 1ns / 1ps

package lvif_pkg;

  // sample and payload widths
  localparam int SAMPLE_W   = 16;
  localparam int COEF_W     = 8;
  localparam int PROD_W     = SAMPLE_W + COEF_W;
  localparam int ACC_W      = 27;
  localparam int FILL_W     = 3;
  localparam int WIN_DEPTH  = 7;
  localparam int WIN_TAPS   = WIN_DEPTH + 1;
  localparam int NUM_OPS    = 6;
  localparam int NUM_PHASES = 4;

  // queue depths
  localparam int MID_DEPTH_DEF = 2;
  localparam int OUT_DEPTH_DEF = 8;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAC_POSITION = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_RAW_OUTPUT    = 1'b1;

  // phase that selects the symmetric 8-tap half-sample filter
  localparam logic [1:0] HALF_PHASE = 2'd2;

  // fill levels needed before a result comes out
  localparam logic [FILL_W-1:0] NEED_7TAP = 3'd6;
  localparam logic [FILL_W-1:0] NEED_8TAP = 3'd7;
  localparam logic [FILL_W-1:0] FILL_MAX  = 3'd7;

  // output scaling
  localparam int PIXEL_OFFSET = 257 << 11;
  localparam int PIXEL_SHIFT  = 12;
  localparam int RAW_SHIFT    = 6;
  localparam int PIXEL_MAX    = 255;
  localparam int INT16_MAX    = 32767;
  localparam int INT16_MIN    = -32768;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [COEF_W-1:0]   coef_t;

  // coefficient per operand slot; the half row applies to the pre-added pairs
  localparam coef_t TAPS [NUM_PHASES][NUM_OPS] = '{
    '{ 8'sd0,  8'sd0,   8'sd0,  8'sd64,  8'sd0,   8'sd0 },
    '{-8'sd1,  8'sd4,  -8'sd10, 8'sd58,  8'sd17, -8'sd5 },
    '{-8'sd1,  8'sd4,  -8'sd11, 8'sd40,  8'sd0,   8'sd0 },
    '{ 8'sd1, -8'sd5,   8'sd17, 8'sd58, -8'sd10,  8'sd4 }
  };

  typedef struct packed {
    sample_t sample;
    logic    column_start;
    logic    column_end;
  } lvif_in_t;

  typedef struct packed {
    sample_t filtered_value;
    logic    last_of_column;
  } lvif_out_t;

  // work handed from front to back: window oldest first, newest sample on top
  typedef struct packed {
    sample_t [WIN_TAPS-1:0] win;
    logic                   last;
  } lvif_desc_t;

endpackage

[hdl/luma_vertical_interp_filter_core.sv]
// top level of the luma vertical interpolation filter
`timescale 1ns / 1ps

// Vertical second pass of luma sub-pixel interpolation, one column at a time.
// Input side is a queue: drive in_data_i and push; a beat is taken on a clock
// edge with push high and full low. Samples arrive top to bottom; column_start
// opens a column, column_end closes it. Result side is a queue: while empty is
// low the oldest result sits on out_data_o, and pop takes it.
// Every input beat once the window holds 6 samples (7 for the half phase)
// gives exactly one result; earlier beats of a column give none.
// A result passes through the middle queue and the operand, multiply and sum
// stages before it shows on out_data_o. Throughput: one beat per cycle on both
// sides while the receiver keeps up, set by the single multiply/add pipeline.
// When the receiver stalls, results collect in an OUT_DEPTH entry output
// queue; the pipeline only starts work it has room for, so the middle queue
// fills and then full goes high until pop frees space. Reset clears both queues,
// the window fill and the config. Configuration (frac_position, raw_output) is
// written via cfg_we_i by the user only while idle; the block does not enforce it.
module luma_vertical_interp_filter_core import lvif_pkg::*; #(
  parameter int MID_DEPTH = MID_DEPTH_DEF,
  parameter int OUT_DEPTH = OUT_DEPTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push,
  output logic                  full,
  input  lvif_in_t              in_data_i,
  output logic                  empty,
  input  logic                  pop,
  output lvif_out_t             out_data_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  localparam int MID_CNT_W = $clog2(MID_DEPTH + 1);
  localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

  logic [1:0]           frac_q;
  logic                 raw_q;
  logic                 accept;
  logic                 mid_push, mid_full, mid_pop, mid_empty;
  lvif_desc_t           mid_wdata, mid_rdata;
  logic [MID_CNT_W-1:0] mid_count;
  logic                 out_push, out_full;
  lvif_out_t            out_wdata;
  logic [OUT_CNT_W-1:0] out_count;

  assign accept = push && !full;
  assign full   = mid_full;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frac_q <= '0;
      raw_q  <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_FRAC_POSITION: frac_q <= cfg_wdata_i[1:0];
        CFG_RAW_OUTPUT:    raw_q  <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // front end
  lvif_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .item_i       (in_data_i),
    .half_i       (frac_q == HALF_PHASE),
    .desc_valid_o (mid_push),
    .desc_o       (mid_wdata)
  );

  // queue between front and back
  lvif_fifo #(
    .DEPTH (MID_DEPTH),
    .WIDTH ($bits(lvif_desc_t))
  ) u_mid_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (mid_push),
    .data_i  (mid_wdata),
    .full_o  (mid_full),
    .pop_i   (mid_pop),
    .data_o  (mid_rdata),
    .empty_o (mid_empty),
    .count_o (mid_count)
  );

  // filter pipeline
  lvif_back #(
    .OUT_DEPTH (OUT_DEPTH)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .frac_position_i (frac_q),
    .raw_output_i    (raw_q),
    .desc_empty_i    (mid_empty),
    .desc_i          (mid_rdata),
    .desc_pop_o      (mid_pop),
    .out_count_i     (out_count),
    .out_push_o      (out_push),
    .out_data_o      (out_wdata)
  );

  // result queue
  lvif_fifo #(
    .DEPTH (OUT_DEPTH),
    .WIDTH ($bits(lvif_out_t))
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (out_push),
    .data_i  (out_wdata),
    .full_o  (out_full),
    .pop_i   (pop),
    .data_o  (out_data_o),
    .empty_o (empty),
    .count_o (out_count)
  );

`ifndef SYNTHESIS
  // the pipeline never delivers into a full result queue
  a_out_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_push |-> !out_full)
    else $error("result written while result queue full");

  // the middle queue count stays within its depth
  a_mid_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mid_count <= MID_CNT_W'(MID_DEPTH))
    else $error("middle queue count out of range");

  // a one-sample column never produces a result
  a_single_sample_column: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_data_i.column_start && in_data_i.column_end) |-> !mid_push)
    else $error("single-sample column produced a result");

  // a beat leaves the middle queue only when it enters the pipeline
  a_issue_tracks_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mid_pop && !mid_empty) |=> u_back.v1_q)
    else $error("pipeline stage lost a popped beat");
`endif

endmodule

[hdl/lvif_fifo.sv]
// small flop-based first-in first-out queue with occupancy count
`timescale 1ns / 1ps

module lvif_fifo #(
  parameter int DEPTH = 2,
  parameter int WIDTH = 8,
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o,
  output logic [CNT_W-1:0] count_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign empty_o = (count_q == '0);
  assign count_o = count_q;
  assign data_o  = mem[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // pointer and count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem[wr_ptr_q] <= data_i;
    end
  end

endmodule

[hdl/lvif_front.sv]
// front end: delay line, window fill tracking and result classification
`timescale 1ns / 1ps

module lvif_front import lvif_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  lvif_in_t   item_i,
  input  logic       half_i,
  output logic       desc_valid_o,
  output lvif_desc_t desc_o
);

  sample_t           win_q [WIN_DEPTH];
  logic [FILL_W-1:0] fill_q, fill_d;
  logic [FILL_W-1:0] need;
  logic              window_ready;

  // a column start empties the window before this sample is looked at
  assign need         = half_i ? NEED_8TAP : NEED_7TAP;
  assign window_ready = !item_i.column_start && (fill_q >= need);
  assign desc_valid_o = accept_i && window_ready;

  // snapshot of the window plus the current sample
  always_comb begin
    for (int i = 0; i < WIN_DEPTH; i++) begin
      desc_o.win[i] = win_q[i];
    end
    desc_o.win[WIN_DEPTH] = item_i.sample;
    desc_o.last           = item_i.column_end;
  end

  // fill count: saturating, cleared at column boundaries
  always_comb begin
    fill_d = fill_q;
    if (accept_i) begin
      if (item_i.column_end) begin
        fill_d = '0;
      end else if (item_i.column_start) begin
        fill_d = FILL_W'(1);
      end else if (fill_q != FILL_MAX) begin
        fill_d = fill_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else begin
      fill_q <= fill_d;
    end
  end

  // delay line shifts by one sample per beat
  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      for (int i = 0; i < WIN_DEPTH - 1; i++) begin
        win_q[i] <= win_q[i + 1];
      end
      win_q[WIN_DEPTH-1] <= item_i.sample;
    end
  end

endmodule

[hdl/lvif_back.sv]
// back end: operand prep, tap multiply, sum and output scaling pipeline
`timescale 1ns / 1ps

module lvif_back import lvif_pkg::*; #(
  parameter int OUT_DEPTH = OUT_DEPTH_DEF,
  localparam int CNT_W = $clog2(OUT_DEPTH + 1),
  localparam int SUM_W = CNT_W + 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [1:0]       frac_position_i,
  input  logic             raw_output_i,
  input  logic             desc_empty_i,
  input  lvif_desc_t       desc_i,
  output logic             desc_pop_o,
  input  logic [CNT_W-1:0] out_count_i,
  output logic             out_push_o,
  output lvif_out_t        out_data_o
);

  logic                    v1_q, v2_q, v3_q;
  sample_t                 op_q   [NUM_OPS];
  coef_t                   coef_q [NUM_OPS];
  logic signed [PROD_W-1:0] prod_q [NUM_OPS];
  logic signed [ACC_W-1:0] acc_q;
  logic                    last1_q, last2_q, last3_q;

  sample_t                 op_d [NUM_OPS];
  logic signed [ACC_W-1:0] acc_d;
  logic [SUM_W-1:0]        committed;
  logic                    issue;

  // issue only when the output queue has room for everything in flight
  assign committed = SUM_W'(out_count_i) + SUM_W'(v1_q) + SUM_W'(v2_q) + SUM_W'(v3_q);
  assign issue      = !desc_empty_i && (committed < SUM_W'(OUT_DEPTH));
  assign desc_pop_o = issue;

  // operand select: mirrored pair sums, or edge difference and plain samples
  always_comb begin
    if (frac_position_i == HALF_PHASE) begin
      for (int i = 0; i < NUM_OPS; i++) begin
        op_d[i] = '0;
      end
      for (int i = 0; i < 4; i++) begin
        op_d[i] = desc_i.win[i] + desc_i.win[WIN_TAPS-1-i];
      end
    end else begin
      op_d[0] = desc_i.win[1] - desc_i.win[WIN_TAPS-1];
      for (int i = 1; i < NUM_OPS; i++) begin
        op_d[i] = desc_i.win[i+1];
      end
    end
  end

  // adder over the six products
  always_comb begin
    acc_d = '0;
    for (int i = 0; i < NUM_OPS; i++) begin
      acc_d = acc_d + ACC_W'(prod_q[i]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= issue;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // stage registers
  always_ff @(posedge clk_i) begin
    if (issue) begin
      for (int i = 0; i < NUM_OPS; i++) begin
        op_q[i]   <= op_d[i];
        coef_q[i] <= TAPS[frac_position_i][i];
      end
      last1_q <= desc_i.last;
    end
    if (v1_q) begin
      for (int i = 0; i < NUM_OPS; i++) begin
        prod_q[i] <= PROD_W'(op_q[i]) * PROD_W'(coef_q[i]);
      end
      last2_q <= last1_q;
    end
    if (v2_q) begin
      acc_q   <= acc_d;
      last3_q <= last2_q;
    end
  end

  // output scaling: rounded pixel clip or raw shift with int16 saturation
  logic signed [ACC_W-1:0] pix_sum, pix_sh, raw_sh;
  sample_t                 result;

  always_comb begin
    pix_sum = acc_q + ACC_W'(PIXEL_OFFSET);
    pix_sh  = pix_sum >>> PIXEL_SHIFT;
    raw_sh  = acc_q >>> RAW_SHIFT;
    if (raw_output_i) begin
      if (raw_sh > ACC_W'(INT16_MAX)) begin
        result = SAMPLE_W'(INT16_MAX);
      end else if (raw_sh < ACC_W'(INT16_MIN)) begin
        result = SAMPLE_W'(INT16_MIN);
      end else begin
        result = raw_sh[SAMPLE_W-1:0];
      end
    end else begin
      if (pix_sh < 0) begin
        result = '0;
      end else if (pix_sh > ACC_W'(PIXEL_MAX)) begin
        result = SAMPLE_W'(PIXEL_MAX);
      end else begin
        result = pix_sh[SAMPLE_W-1:0];
      end
    end
  end

  assign out_push_o                = v3_q;
  assign out_data_o.filtered_value = result;
  assign out_data_o.last_of_column = last3_q;

endmodule

[verif/luma_vertical_interp_filter_core_tb.sv]
// self-checking testbench for the luma vertical interpolation filter core
`timescale 1ns / 1ps

module luma_vertical_interp_filter_core_tb;
  import lvif_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 16;
  localparam int BEATS_PER_SET = 50;
  localparam int NUM_SETS      = 10;
  localparam longint PIX_ROUND = 257 << 11;

  // quarter phases: taps for the folded outer pair, then the five inner samples
  localparam int QUARTER_TAPS [4][6] = '{
    '{ 0,  0,   0, 64,   0,  0},
    '{-1,  4, -10, 58,  17, -5},
    '{ 0,  0,   0,  0,   0,  0},
    '{ 1, -5,  17, 58, -10,  4}
  };
  // half phase: taps for the four mirrored pairs, outermost first
  localparam int HALF_TAPS [4] = '{-1, 4, -11, 40};

  typedef enum int {POP_ALWAYS, POP_COIN, POP_SPARSE} pop_mode_e;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  push;
  logic                  full;
  lvif_in_t              in_data_i;
  logic                  empty;
  logic                  pop;
  lvif_out_t             out_data_o;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  // filter state as the block should hold it
  sample_t    win_q [WIN_DEPTH];
  int         fill_q;
  logic [1:0] phase_q;
  logic       raw_q;

  lvif_out_t pending_results_q [$];
  lvif_out_t want_beat;

  int  fail_count;
  int  beats_sent;
  int  results_checked;
  int  full_wait_cycles;
  int  hold_off_left;
  bit  gaps_on;
  int  burst_left;

  luma_vertical_interp_filter_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .in_data_i   (in_data_i),
    .empty       (empty),
    .pop         (pop),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // run guard
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("timeout after %0d cycles, %0d results still pending", CYCLE_LIMIT,
             pending_results_q.size());
    $display("luma_vertical_interp_filter_core verification failed");
    $finish;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    fail_count++;
    if (fail_count <= 30)
      $display("%0t: %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  // next filtered output for one accepted beat, then shift the delay line
  function automatic void interp_predict(input lvif_in_t b);
    longint    acc;
    longint    scaled;
    sample_t   taps_in [8];
    sample_t   folded;
    lvif_out_t r;
    int        need;
    acc = 0;
    need = (phase_q == HALF_PHASE) ? 7 : 6;
    if (b.column_start) fill_q = 0;
    if (fill_q >= need) begin
      if (phase_q == HALF_PHASE) begin
        for (int i = 0; i < 7; i++) taps_in[i] = win_q[i];
        taps_in[7] = b.sample;
        // mirrored pairs add with 16-bit wrap
        for (int i = 0; i < 4; i++) begin
          folded = taps_in[i] + taps_in[7-i];
          acc += longint'(folded) * HALF_TAPS[i];
        end
      end else begin
        for (int i = 0; i < 6; i++) taps_in[i] = win_q[i+1];
        taps_in[6] = b.sample;
        // outer pair subtracts with 16-bit wrap
        folded = taps_in[0] - taps_in[6];
        acc = longint'(folded) * QUARTER_TAPS[phase_q][0];
        for (int i = 1; i < 6; i++)
          acc += longint'(taps_in[i]) * QUARTER_TAPS[phase_q][i];
      end
      if (raw_q) begin
        scaled = acc >>> 6;
        if (scaled > 32767) scaled = 32767;
        if (scaled < -32768) scaled = -32768;
      end else begin
        scaled = (acc + PIX_ROUND) >>> 12;
        if (scaled > 255) scaled = 255;
        if (scaled < 0) scaled = 0;
      end
      r.filtered_value = scaled[15:0];
      r.last_of_column = b.column_end;
      pending_results_q.push_back(r);
    end
    for (int i = 0; i < WIN_DEPTH - 1; i++) win_q[i] = win_q[i+1];
    win_q[WIN_DEPTH-1] = b.sample;
    if (fill_q < 7) fill_q++;
    if (b.column_end) fill_q = 0;
  endfunction

  function automatic lvif_in_t make_beat(input int value, input bit first, input bit last);
    lvif_in_t b;
    b.sample       = sample_t'(value);
    b.column_start = first;
    b.column_end   = last;
    return b;
  endfunction

  function automatic int pick_sample();
    int value;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0:       value = 32767;
          1:       value = -32768;
          2:       value = 0;
          default: value = -1;
        endcase
      end
      // range where pixel mode lands between the clip limits
      1, 2, 3: value = int'($urandom_range(0, 16600)) - 8300;
      default: value = int'($urandom_range(0, 65535)) - 32768;
    endcase
    return value;
  endfunction

  // offer one beat, in bursts with random gaps, and hold it until taken
  task automatic send_beat(input lvif_in_t b);
    int gap;
    if (gaps_on && burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 50) : $urandom_range(1, 12);
      gap = $urandom_range(1, 6);
      repeat (gap) begin
        @(negedge clk_i);
        push <= 1'b0;
      end
    end
    if (burst_left > 0) burst_left--;
    @(negedge clk_i);
    push      <= 1'b1;
    in_data_i <= b;
    @(posedge clk_i);
    while (full) begin
      full_wait_cycles++;
      @(posedge clk_i);
    end
    beats_sent++;
    interp_predict(b);
  endtask

  // stop offering, wait for every pending result, then let the pipeline settle
  task automatic drain_all();
    @(negedge clk_i);
    push <= 1'b0;
    while (pending_results_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value[CFG_DATA_W-1:0];
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_FRAC_POSITION)
      phase_q = value[1:0];
    else
      raw_q = value[0];
  endtask

  task automatic set_mode(input int phase, input int raw);
    write_reg(CFG_FRAC_POSITION, phase);
    write_reg(CFG_RAW_OUTPUT, raw);
  endtask

  // one-sample column, then a column that opens without a start marker
  task automatic test_column_markers();
    drain_all();
    set_mode(0, 0);
    send_beat(make_beat(100, 1'b1, 1'b1));
    send_beat(make_beat(8000, 1'b0, 1'b0));
    send_beat(make_beat(-8000, 1'b0, 1'b0));
    send_beat(make_beat(1, 1'b0, 1'b0));
    send_beat(make_beat(2, 1'b0, 1'b0));
    send_beat(make_beat(3, 1'b0, 1'b0));
    send_beat(make_beat(4, 1'b0, 1'b0));
    send_beat(make_beat(5, 1'b0, 1'b1));
  endtask

  // full-scale samples: wrap in the folded pairs, saturation and clipping
  task automatic test_extremes();
    drain_all();
    set_mode(1, 1);
    for (int i = 0; i < 9; i++)
      send_beat(make_beat((i % 2 == 0) ? 32767 : -32768, i == 0, i == 8));
    drain_all();
    set_mode(HALF_PHASE, 0);
    for (int i = 0; i < 8; i++)
      send_beat(make_beat((i % 4 < 2) ? 32767 : -32768, i == 0, i == 7));
  endtask

  // random columns under every setting; the first column of each setting
  // carries on whatever the previous one left open
  task automatic test_random_columns();
    int  phase;
    int  raw;
    int  sent;
    int  len;
    int  kind;
    bit  first;
    bit  last;
    bit  last_column;
    for (int set_idx = 0; set_idx < NUM_SETS; set_idx++) begin
      drain_all();
      if (set_idx < 8) begin
        phase = set_idx % 4;
        raw   = set_idx / 4;
      end else begin
        phase = $urandom_range(0, 3);
        raw   = $urandom_range(0, 1);
      end
      set_mode(phase, raw);
      sent = 0;
      while (sent < BEATS_PER_SET) begin
        kind = $urandom_range(0, 9);
        len = (kind < 8) ? $urandom_range(8, 24) : $urandom_range(1, 6);
        last_column = (sent + len >= BEATS_PER_SET);
        for (int k = 0; k < len; k++) begin
          first = (k == 0 && kind != 9 && sent != 0) || ($urandom_range(0, 31) == 0);
          last = (k == len - 1) && ($urandom_range(0, 7) != 0);
          if (last && last_column && $urandom_range(0, 1) == 0) last = 1'b0;
          send_beat(make_beat(pick_sample(), first, last));
        end
        sent += len;
      end
    end
  endtask

  // receiver holds off while a long column streams in without gaps
  task automatic test_backpressure();
    drain_all();
    set_mode(3, 0);
    hold_off_left = 150;
    gaps_on = 1'b0;
    for (int i = 0; i < 48; i++)
      send_beat(make_beat(pick_sample(), i == 0, i == 47));
    gaps_on = 1'b1;
  endtask

  // receiver: stall pattern that changes its character over time
  initial begin
    pop_mode_e mode;
    int        mode_left;
    mode = POP_ALWAYS;
    mode_left = 0;
    pop = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off_left > 0) begin
        pop <= 1'b0;
        hold_off_left--;
      end else begin
        if (mode_left == 0) begin
          mode = pop_mode_e'($urandom_range(0, 2));
          mode_left = $urandom_range(20, 100);
        end
        mode_left--;
        case (mode)
          POP_ALWAYS: pop <= 1'b1;
          POP_COIN:   pop <= 1'($urandom_range(0, 1));
          default:    pop <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // result check against the oldest pending prediction
  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) begin
      if (pending_results_q.size() == 0) begin
        report_mismatch("result with none pending, value", int'(out_data_o.filtered_value), 0);
      end else begin
        want_beat = pending_results_q.pop_front();
        results_checked++;
        if (out_data_o.filtered_value != want_beat.filtered_value)
          report_mismatch("filtered_value", int'(out_data_o.filtered_value),
                          int'(want_beat.filtered_value));
        if (out_data_o.last_of_column != want_beat.last_of_column)
          report_mismatch("last_of_column", int'(out_data_o.last_of_column),
                          int'(want_beat.last_of_column));
      end
    end
  end

  initial begin
    rst_ni      = 1'b0;
    push        = 1'b0;
    in_data_i   = '0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = '0;
    cfg_wdata_i = '0;
    for (int i = 0; i < WIN_DEPTH; i++) win_q[i] = '0;
    fill_q           = 0;
    phase_q          = '0;
    raw_q            = 1'b0;
    fail_count       = 0;
    beats_sent       = 0;
    results_checked  = 0;
    full_wait_cycles = 0;
    hold_off_left    = 0;
    gaps_on          = 1'b1;
    burst_left       = 0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_column_markers();
    test_extremes();
    test_random_columns();
    test_backpressure();
    drain_all();

    $display("covered: %0d beats in, %0d results checked, %0d cycles with input stalled",
             beats_sent, results_checked, full_wait_cycles);
    $display("all four phases in pixel and raw mode, column markers, open columns");
    if (fail_count == 0) begin
      $display("luma_vertical_interp_filter_core verification clean");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("luma_vertical_interp_filter_core verification failed");
    end
    $finish;
  end

endmodule

[sim.f]
hdl/lvif_pkg.sv
hdl/lvif_fifo.sv
hdl/lvif_front.sv
hdl/lvif_back.sv
hdl/luma_vertical_interp_filter_core.sv
verif/luma_vertical_interp_filter_core_tb.sv
